@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the linked-list pool.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ALP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expr must never be true at a clock edge outside reset
`define ALP_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ src/alp_pkg.sv @@
// Shared types, codes and the control store of the linked-list pool.
// No dependencies.
package alp_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OP_W         = 2;
    localparam int VALUE_W      = 32;
    localparam int SLOT_W       = 5;

    typedef enum logic [OP_W-1:0] {
        OP_HEAD   = 2'd0,
        OP_TAIL   = 2'd1,
        OP_ORD    = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    // control store addresses
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_ALLOC,
        ST_CHOOSE,
        ST_HEADLINK,
        ST_TWALK,
        ST_LINK,
        ST_SPLICE,
        ST_SRCH,
        ST_SRES,
        ST_EOK,
        ST_EFAIL,
        ST_EFOUND
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_HAS_FREE,
        C_IS_SEARCH,
        C_IS_HEAD,
        C_TAIL_CONT,
        C_SRCH_CONT,
        C_MATCH,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ALLOC,
        ACT_ADVANCE,
        ACT_LINK_NEW,
        ACT_SPLICE,
        ACT_HEAD_LINK,
        ACT_EMIT_OK,
        ACT_EMIT_FAIL,
        ACT_EMIT_FOUND
    } act_t;

    // one control word: the action fires and t_true is taken when cond holds
    typedef struct packed {
        cond_t cond;
        step_t t_true;
        step_t t_false;
        act_t  act;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic has_free;
        logic is_search;
        logic is_head;
        logic tail_cont;
        logic srch_cont;
        logic match;
        logic out_free;
    } flags_t;

    typedef struct packed {
        act_t act;
        logic fire;
    } ctrl_t;

    function automatic ucode_t ucode(input step_t step);
        ucode_t cw;
        case (step)
            ST_IDLE:     cw = '{C_ACCEPT,    ST_DISP,     ST_IDLE,   ACT_LOAD};
            ST_DISP:     cw = '{C_IS_SEARCH, ST_SRCH,     ST_ALLOC,  ACT_NONE};
            ST_ALLOC:    cw = '{C_HAS_FREE,  ST_CHOOSE,   ST_EFAIL,  ACT_ALLOC};
            ST_CHOOSE:   cw = '{C_IS_HEAD,   ST_HEADLINK, ST_TWALK,  ACT_NONE};
            ST_HEADLINK: cw = '{C_ALWAYS,    ST_EOK,      ST_EOK,    ACT_HEAD_LINK};
            ST_TWALK:    cw = '{C_TAIL_CONT, ST_TWALK,    ST_LINK,   ACT_ADVANCE};
            ST_LINK:     cw = '{C_ALWAYS,    ST_SPLICE,   ST_SPLICE, ACT_LINK_NEW};
            ST_SPLICE:   cw = '{C_ALWAYS,    ST_EOK,      ST_EOK,    ACT_SPLICE};
            ST_SRCH:     cw = '{C_SRCH_CONT, ST_SRCH,     ST_SRES,   ACT_ADVANCE};
            ST_SRES:     cw = '{C_MATCH,     ST_EFOUND,   ST_EFAIL,  ACT_NONE};
            ST_EOK:      cw = '{C_OUT_FREE,  ST_IDLE,     ST_EOK,    ACT_EMIT_OK};
            ST_EFAIL:    cw = '{C_OUT_FREE,  ST_IDLE,     ST_EFAIL,  ACT_EMIT_FAIL};
            ST_EFOUND:   cw = '{C_OUT_FREE,  ST_IDLE,     ST_EFOUND, ACT_EMIT_FOUND};
            default:     cw = '{C_ALWAYS,    ST_IDLE,     ST_IDLE,   ACT_NONE};
        endcase
        return cw;
    endfunction

endpackage

@@ src/alp_if.sv @@
// Valid/ready channel interfaces: request words in, result words out.
// Depends on alp_pkg.
interface alp_req_if;
    logic                               valid;
    logic                               ready;
    logic [alp_pkg::OP_W-1:0]           op;
    logic signed [alp_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface alp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [alp_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output ok, output slot, input ready);
    modport sink   (input valid, input ok, input slot, output ready);
endinterface

@@ src/alp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/alp_seq.sv @@
// Microcode sequencer: step counter, control store lookup, branch select.
// Depends on alp_pkg.
module alp_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  alp_pkg::flags_t flags,
    output alp_pkg::ctrl_t  ctrl
);
    alp_pkg::step_t  upc_reg;
    alp_pkg::step_t  upc_next;
    alp_pkg::ucode_t cw;
    logic            hit;

    always_comb
    begin
        cw = alp_pkg::ucode(upc_reg);
        case (cw.cond)
            alp_pkg::C_ALWAYS:    hit = 1'b1;
            alp_pkg::C_ACCEPT:    hit = flags.accept;
            alp_pkg::C_HAS_FREE:  hit = flags.has_free;
            alp_pkg::C_IS_SEARCH: hit = flags.is_search;
            alp_pkg::C_IS_HEAD:   hit = flags.is_head;
            alp_pkg::C_TAIL_CONT: hit = flags.tail_cont;
            alp_pkg::C_SRCH_CONT: hit = flags.srch_cont;
            alp_pkg::C_MATCH:     hit = flags.match;
            alp_pkg::C_OUT_FREE:  hit = flags.out_free;
            default:              hit = 1'b0;
        endcase
        upc_next  = hit ? cw.t_true : cw.t_false;
        ctrl.act  = cw.act;
        ctrl.fire = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= alp_pkg::ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end
endmodule

@@ src/alp_datapath.sv @@
// Pool datapath: value and link RAMs, list/free heads, walk registers,
// result register. Depends on alp_pkg, alp_if, alp_ram.
module alp_datapath #(
    parameter int CAPACITY = alp_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  alp_pkg::ctrl_t  ctrl,
    output alp_pkg::flags_t flags,
    alp_req_if.sink         request,
    alp_rsp_if.source       result
);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int VW = alp_pkg::VALUE_W;
    localparam int SW = alp_pkg::SLOT_W;
    localparam logic [IW-1:0] CAP = IW'(CAPACITY);

    typedef logic [IW-1:0] idx_t;

    // slot field is the low bits of the index
    function automatic logic [SW-1:0] to_slot(input idx_t i);
        logic [SW+IW-1:0] wide;
        wide = {{SW{1'b0}}, i};
        return wide[SW-1:0];
    endfunction

    alp_pkg::op_t   op_reg, op_next;
    logic [VW-1:0]  val_reg, val_next;
    idx_t           pos_reg, pos_next;
    idx_t           prev_reg, prev_next;
    idx_t           steps_reg, steps_next;
    idx_t           new_reg, new_next;
    idx_t           head_reg, head_next;
    idx_t           fill_reg, fill_next;   // free chain is always fill_reg..CAP-1
    logic           out_valid_reg, out_valid_next;
    logic           out_ok_reg, out_ok_next;
    logic [SW-1:0]  out_slot_reg, out_slot_next;

    logic           val_we;
    logic [VW-1:0]  val_rd;
    logic           link_we;
    idx_t           link_waddr;
    idx_t           link_wdata;
    idx_t           link_rd;
    idx_t           rd_idx;
    idx_t           pos_clamp;
    logic           in_range;
    logic           less;

    alp_ram #(.W(VW), .D(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (val_reg),
        .raddr (rd_idx[AW-1:0]),
        .rdata (val_rd)
    );

    alp_ram #(.W(IW), .D(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr[AW-1:0]),
        .wdata (link_wdata),
        .raddr (rd_idx[AW-1:0]),
        .rdata (link_rd)
    );

    // read data belongs to pos_reg, except after an idle step in which no request was taken
    assign in_range  = (pos_reg < CAP) && (steps_reg < CAP);
    assign less      = $signed(val_rd) < $signed(val_reg);
    assign pos_clamp = (pos_reg > CAP) ? CAP : pos_reg;

    always_comb
    begin
        flags.accept    = request.valid;
        flags.has_free  = fill_reg < CAP;
        flags.is_search = op_reg == alp_pkg::OP_SEARCH;
        flags.is_head   = op_reg == alp_pkg::OP_HEAD;
        flags.tail_cont = in_range && ((op_reg != alp_pkg::OP_ORD) || less);
        flags.srch_cont = in_range && (val_rd != val_reg);
        flags.match     = in_range && (val_rd == val_reg);
        flags.out_free  = !out_valid_reg || result.ready;
    end

    assign request.ready = ctrl.act == alp_pkg::ACT_LOAD;
    assign result.valid  = out_valid_reg;
    assign result.ok     = out_ok_reg;
    assign result.slot   = out_slot_reg;

    always_comb
    begin
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        new_next       = new_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_slot_next  = out_slot_reg;
        val_we         = 1'b0;
        link_we        = 1'b0;
        link_waddr     = new_reg;
        link_wdata     = CAP;
        rd_idx         = pos_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.act)
            alp_pkg::ACT_LOAD:
            begin
                rd_idx = head_reg;
                if (ctrl.fire)
                begin
                    op_next    = alp_pkg::op_t'(request.op);
                    val_next   = request.value;
                    pos_next   = head_reg;
                    prev_next  = CAP;
                    steps_next = '0;
                end
            end
            alp_pkg::ACT_ALLOC:
            begin
                if (ctrl.fire)
                begin
                    new_next  = fill_reg;
                    fill_next = fill_reg + IW'(1);
                    val_we    = 1'b1;
                end
            end
            alp_pkg::ACT_ADVANCE:
            begin
                if (ctrl.fire)
                begin
                    prev_next  = pos_reg;
                    pos_next   = link_rd;
                    steps_next = steps_reg + IW'(1);
                    rd_idx     = link_rd;
                end
            end
            alp_pkg::ACT_LINK_NEW:
            begin
                if (ctrl.fire)
                begin
                    link_we    = 1'b1;
                    link_wdata = (op_reg == alp_pkg::OP_ORD) ? pos_clamp : CAP;
                end
            end
            alp_pkg::ACT_SPLICE:
            begin
                if (ctrl.fire)
                begin
                    if (prev_reg >= CAP)
                    begin
                        head_next = new_reg;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = new_reg;
                    end
                end
            end
            alp_pkg::ACT_HEAD_LINK:
            begin
                if (ctrl.fire)
                begin
                    link_we    = 1'b1;
                    link_wdata = head_reg;
                    head_next  = new_reg;
                end
            end
            alp_pkg::ACT_EMIT_OK:
            begin
                if (ctrl.fire)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    out_slot_next  = to_slot(new_reg);
                end
            end
            alp_pkg::ACT_EMIT_FAIL:
            begin
                if (ctrl.fire)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b0;
                    out_slot_next  = to_slot(CAP);
                end
            end
            alp_pkg::ACT_EMIT_FOUND:
            begin
                if (ctrl.fire)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    out_slot_next  = to_slot(pos_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= CAP;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        new_reg      <= new_next;
        out_ok_reg   <= out_ok_next;
        out_slot_reg <= out_slot_next;
    end
endmodule

@@ src/array_linked_list_pool_unit.sv @@
// Top level of the array-backed linked-list pool with free chain.
// Depends on alp_pkg, alp_if, alp_seq, alp_datapath, assert_macros.svh.
//
// Use: a request word (op, value) on the request channel inserts value at
// the head, at the tail or in ascending order, or searches for it. Each
// request gives exactly one result word (ok, slot) on the result channel.
// A full pool rejects inserts (ok=0, slot=CAPACITY, low 5 bits).
// Flow: requests are taken one at a time; the next one can be taken in
// the same cycle that the result turns valid. A head insert allocates a
// slot and links it at the head; a tail or ordered insert walks the list,
// then links the new slot and splices it in; a search walks the list until
// a match or its end. A walk follows at most CAPACITY links, one link per
// cycle, bounded by the registered read of the link and value RAMs.
// Reset: list empty, every slot free in index order; the free chain is
// kept as a fill count, so no clearing pass is needed and the block is
// ready as soon as reset is released.
// Stall: the result sits in an output register; the next request is taken
// while it waits, and the sequencer only holds at its emit step if the
// register is still full when the next result is due.
`include "assert_macros.svh"

module array_linked_list_pool_unit #(
    parameter int CAPACITY = alp_pkg::CAPACITY_DEF
) (
    input logic       clk,
    input logic       rst_n,
    alp_req_if.sink   request,
    alp_rsp_if.source result
);
    localparam logic [alp_pkg::SLOT_W-1:0] SLOT_NONE = alp_pkg::SLOT_W'(CAPACITY);

    alp_pkg::flags_t flags;
    alp_pkg::ctrl_t  ctrl;
    logic            req_take;
    logic            emit_fire;

    // control store and step counter
    alp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // memories, pointers, walk registers and result register
    alp_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .flags   (flags),
        .request (request),
        .result  (result)
    );

    assign req_take  = request.valid && request.ready;
    assign emit_fire = ctrl.fire && (ctrl.act inside {alp_pkg::ACT_EMIT_OK,
                                                      alp_pkg::ACT_EMIT_FAIL,
                                                      alp_pkg::ACT_EMIT_FOUND});

    // one request in flight: never ready right after an accept
    `ALP_ASSERT(a_one_in_flight, req_take |=> !request.ready, "request taken while busy")

    // an emit step that fires always lands in the result register
    `ALP_ASSERT(a_emit_lands, emit_fire |=> result.valid, "emitted result lost")

    // a failed result always reports the empty slot code
    `ALP_NEVER(a_fail_slot, result.valid && !result.ok && (result.slot != SLOT_NONE), "fail slot")
endmodule

@@ bench/tb.sv @@
// Self-checking bench for array_linked_list_pool_unit: inserts and searches
// over valid/ready channels, checked word by word against a list predictor.
// Depends on alp_pkg, alp_if and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alp_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } result_word_t;

    // Mirror of the pool: value and link stores, list head, free-chain head.
    // Every accepted request word queues the result word it must produce.
    class pool_tracker;
        logic signed [VALUE_W-1:0] value_store [CAP];
        logic [SLOT_W-1:0]         link_store [CAP];
        logic [SLOT_W-1:0]         list_head;
        logic [SLOT_W-1:0]         free_head;
        result_word_t              awaited [$];
        int                        mismatches;

        function new();
            for (int i = 0; i < CAP; i++)
            begin
                value_store[i] = '0;
                link_store[i]  = SLOT_W'(i + 1);
            end
            list_head  = SLOT_W'(CAP);
            free_head  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(input op_t op, input logic signed [VALUE_W-1:0] value);
            result_word_t      r;
            logic [SLOT_W-1:0] s;
            logic [SLOT_W-1:0] pos;
            logic [SLOT_W-1:0] prev;
            r = '{1'b0, SLOT_W'(CAP)};
            if (op == OP_SEARCH)
            begin
                // first match from the head wins
                pos = list_head;
                for (int steps = 0; steps < CAP && pos < CAP; steps++)
                begin
                    if (value_store[pos] == value)
                    begin
                        r = '{1'b1, pos};
                        break;
                    end
                    pos = link_store[pos];
                end
            end
            else if (free_head < CAP)
            begin
                s              = free_head;
                free_head      = link_store[s];
                value_store[s] = value;
                if (op == OP_HEAD)
                begin
                    link_store[s] = list_head;
                    list_head     = s;
                end
                else
                begin
                    // tail: walk to the end; ordered: stop at first element >= value
                    prev = SLOT_W'(CAP);
                    pos  = list_head;
                    for (int steps = 0; steps < CAP && pos < CAP; steps++)
                    begin
                        if (op == OP_ORD && value_store[pos] >= value)
                            break;
                        prev = pos;
                        pos  = link_store[pos];
                    end
                    link_store[s] = (op == OP_ORD) ? pos : SLOT_W'(CAP);
                    if (prev >= CAP)
                        list_head = s;
                    else
                        link_store[prev] = s;
                end
                r = '{1'b1, s};
            end
            awaited.push_back(r);
        endfunction

        function void check_result(input logic ok, input logic [SLOT_W-1:0] slot);
            result_word_t want;
            if (awaited.size() == 0)
            begin
                $error("result word with none expected: ok=%0d slot=%0d", ok, slot);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, ok);
                mismatches++;
            end
            if (slot !== want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, slot);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic no_idle;       // both sides run without gaps while set
    logic hold_request;  // asks the result side for one long hold-off

    logic [VALUE_W-1:0] sent_values [$];  // value of every insert sent, refused or not, for search hits

    pool_tracker tracker = new();

    alp_req_if request_ch ();
    alp_rsp_if result_ch ();

    array_linked_list_pool_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a run that reaches this time is reported as failed.
    initial
    begin
        #5_000_000;
        $display("** array_linked_list_pool_unit: FAILED **");
        $finish;
    end

    // Mix of the value extremes, values of earlier inserts, and full-range noise.
    function automatic logic [VALUE_W-1:0] pick_value();
        int dice;
        dice = $urandom_range(0, 7);
        if (dice == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (dice <= 3 && sent_values.size() != 0)
            return sent_values[$urandom_range(0, sent_values.size() - 1)];
        return $urandom();
    endfunction

    // Offers one request word; returns at the falling edge after acceptance.
    // Entered at a falling edge, so valid gets at most one update per step.
    task automatic send_word(input op_t op, input logic [VALUE_W-1:0] value);
        while (!no_idle && $urandom_range(0, 99) < 34)
        begin
            request_ch.valid <= 1'b0;
            @(negedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.op    <= op;
        request_ch.value <= value;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        tracker.note_request(op, value);
        if (op != OP_SEARCH)
            sent_values.push_back(value);
        @(negedge clk);
    endtask

    // Result side: random ready, with one long hold-off counted here.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 34);
        end
    end

    // Result words are taken at the rising edge where valid and ready meet.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_result(result_ch.ok, result_ch.slot);
    end

    initial
    begin : stimulus
        int                 pick;
        logic [VALUE_W-1:0] v;
        rst_n            = 1'b0;
        no_idle          = 1'b0;
        hold_request     = 1'b0;
        request_ch.valid = 1'b0;
        request_ch.op    = OP_HEAD;
        request_ch.value = '0;
        result_ch.ready  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, extremes, equal values, unsorted ordered insert.
        send_word(OP_SEARCH, 32'h0000_0000);    // search on an empty list
        send_word(OP_ORD,    32'd100);          // ordered insert into empty list
        send_word(OP_HEAD,   32'h8000_0000);    // most negative at the head
        send_word(OP_TAIL,   32'h7FFF_FFFF);    // most positive at the tail
        send_word(OP_ORD,    32'd100);          // equal value goes before the old one
        send_word(OP_ORD,    32'd50);
        send_word(OP_ORD,    32'hFFFF_FFFF);    // -1
        send_word(OP_SEARCH, 32'd100);          // duplicate: first from the head
        send_word(OP_SEARCH, 32'h7FFF_FFFF);    // match at the very end
        send_word(OP_SEARCH, 32'h8000_0000);
        send_word(OP_SEARCH, 32'd12345);        // not found on a non-empty list
        send_word(OP_SEARCH, 32'hFFFF_FFFF);

        // Fill the rest of the pool with random content and mixed placement.
        for (int i = 0; i < CAP - 6; i++)
            send_word(op_t'($urandom_range(0, 2)), pick_value());

        // Pool full: every kind of insert is refused.
        send_word(OP_HEAD, 32'd1);
        send_word(OP_TAIL, 32'd2);
        send_word(OP_ORD,  32'h8000_0000);
        send_word(OP_SEARCH, 32'd2);            // refused value must not be found

        // Random part: half searches (mostly for values sent before), half inserts, which the full pool refuses.
        for (int n = 0; n < 1600; n++)
        begin
            if (n == 300)
                hold_request = 1'b1;            // block fills and stalls the input
            if (n == 900)
            begin
                request_ch.valid <= 1'b0;
                while (tracker.pending() != 0)
                    @(negedge clk);
            end
            no_idle = (n >= 1000 && n < 1200);
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                if ($urandom_range(0, 1) == 1 && sent_values.size() != 0)
                    v = sent_values[$urandom_range(0, sent_values.size() - 1)];
                else
                    v = pick_value();
                send_word(OP_SEARCH, v);
            end
            else
                send_word(op_t'($urandom_range(0, 2)), pick_value());
        end
        request_ch.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("** array_linked_list_pool_unit: PASSED **");
        else
            $display("** array_linked_list_pool_unit: FAILED **");
        $finish;
    end
endmodule
